>>> hw/rtl/twin_door_stepper_sequencer_unit_macros.svh
// -----------------------------------------------------------------------------
// Twin door stepper sequencer - assertion macros
// Clocked implication macros used by the port checker.
// -----------------------------------------------------------------------------
`ifndef TWIN_DOOR_STEPPER_SEQUENCER_UNIT_MACROS_SVH
`define TWIN_DOOR_STEPPER_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TDSS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tdss assertion failed");

// next-cycle implication, disabled during reset
`define TDSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tdss assertion failed");

`endif

>>> hw/rtl/tdss_pkg.sv
// -----------------------------------------------------------------------------
// Twin door stepper sequencer - package
// Types, codes and reset values shared by the sequencer modules.
// -----------------------------------------------------------------------------
package tdss_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [15:0] PULSE_HIGH_RST = 16'd5;
    localparam logic [15:0] PULSE_LOW_RST  = 16'd700;
    localparam logic [15:0] MAX_STEP_RST   = 16'd10000;
    localparam logic [31:0] CLOSE_WAIT_RST = 32'd10000000;
    localparam logic [31:0] SETTLE_RST     = 32'd100000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PULSE_HIGH = 3'd0,
        CFG_PULSE_LOW  = 3'd1,
        CFG_MAX_STEP   = 3'd2,
        CFG_CLOSE_WAIT = 3'd3,
        CFG_SETTLE     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] pulse_high_ticks;
        logic [15:0] pulse_low_ticks;
        logic [15:0] max_step_count;
        logic [31:0] close_wait_ticks;
        logic [31:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic open_request;
        logic close_request;
        logic limit_open_a;
        logic limit_closed_a;
        logic limit_open_b;
        logic limit_closed_b;
    } in_beat_t;

    typedef struct packed {
        logic       step_out_a;
        logic       step_out_b;
        logic       dir_out;
        logic       enable_n_out;
        logic [2:0] phase_out;
    } out_beat_t;

    typedef enum logic [5:0] {
        PH_IDLE         = 6'b000001,
        PH_SETTLE_OPEN  = 6'b000010,
        PH_OPENING      = 6'b000100,
        PH_WAITING      = 6'b001000,
        PH_SETTLE_CLOSE = 6'b010000,
        PH_CLOSING      = 6'b100000
    } phase_t;

    localparam logic [2:0] PHC_IDLE         = 3'd0;
    localparam logic [2:0] PHC_SETTLE_OPEN  = 3'd1;
    localparam logic [2:0] PHC_OPENING      = 3'd2;
    localparam logic [2:0] PHC_WAITING      = 3'd3;
    localparam logic [2:0] PHC_SETTLE_CLOSE = 3'd4;
    localparam logic [2:0] PHC_CLOSING      = 3'd5;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:         code = PHC_IDLE;
            PH_SETTLE_OPEN:  code = PHC_SETTLE_OPEN;
            PH_OPENING:      code = PHC_OPENING;
            PH_WAITING:      code = PHC_WAITING;
            PH_SETTLE_CLOSE: code = PHC_SETTLE_CLOSE;
            PH_CLOSING:      code = PHC_CLOSING;
            default:         code = PHC_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> hw/rtl/tdss_cfg_regs.sv
// -----------------------------------------------------------------------------
// Twin door stepper sequencer - configuration registers
// Decodes writes on the plain write port into the five timing registers.
// -----------------------------------------------------------------------------
module tdss_cfg_regs
    import tdss_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_high_ticks <= PULSE_HIGH_RST;
            cfg_reg.pulse_low_ticks  <= PULSE_LOW_RST;
            cfg_reg.max_step_count   <= MAX_STEP_RST;
            cfg_reg.close_wait_ticks <= CLOSE_WAIT_RST;
            cfg_reg.settle_ticks     <= SETTLE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PULSE_HIGH: cfg_reg.pulse_high_ticks <= cfg_wdata[15:0];
                CFG_PULSE_LOW:  cfg_reg.pulse_low_ticks  <= cfg_wdata[15:0];
                CFG_MAX_STEP:   cfg_reg.max_step_count   <= cfg_wdata[15:0];
                CFG_CLOSE_WAIT: cfg_reg.close_wait_ticks <= cfg_wdata;
                CFG_SETTLE:     cfg_reg.settle_ticks     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/tdss_in_reg.sv
// -----------------------------------------------------------------------------
// Twin door stepper sequencer - input register
// Captures one input beat and holds it until the sequencer takes it.
// -----------------------------------------------------------------------------
module tdss_in_reg
    import tdss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_beat,
    output logic     hold_valid,
    input  logic     hold_take,
    output in_beat_t hold_beat
);

    logic     valid_reg;
    in_beat_t beat_reg;

    assign in_ready = !valid_reg || hold_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= in_beat;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_beat  = beat_reg;

endmodule

>>> hw/rtl/tdss_core.sv
// -----------------------------------------------------------------------------
// Twin door stepper sequencer - sequencing core
// Phase, pulse and step state with the per-tick next-state logic.
// -----------------------------------------------------------------------------
module tdss_core
    import tdss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      advance,
    input  in_beat_t  beat,
    output out_beat_t result
);

    phase_t      phase_reg, phase_next;
    logic        pulse_is_high_reg, pulse_is_high_next;
    logic [31:0] delay_count_reg, delay_count_next;
    logic [15:0] step_count_reg, step_count_next;
    logic [1:0]  motor_active_reg, motor_active_next;
    logic        direction_reg, direction_next;
    logic        enable_n_reg, enable_n_next;

    logic [15:0] hi_ticks;
    logic [15:0] lo_ticks;
    logic        do_step;
    logic [15:0] step_base;
    logic        closing;
    logic [1:0]  step_bits;
    logic [31:0] delay_inc;

    assign hi_ticks  = (cfg.pulse_high_ticks == 16'd0) ? 16'd1 : cfg.pulse_high_ticks;
    assign lo_ticks  = (cfg.pulse_low_ticks == 16'd0) ? 16'd1 : cfg.pulse_low_ticks;
    assign delay_inc = delay_count_reg + 32'd1;

    always_comb begin
        phase_next         = phase_reg;
        pulse_is_high_next = pulse_is_high_reg;
        delay_count_next   = delay_count_reg;
        step_count_next    = step_count_reg;
        motor_active_next  = motor_active_reg;
        direction_next     = direction_reg;
        enable_n_next      = enable_n_reg;
        do_step            = 1'b0;
        step_base          = step_count_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                if (beat.open_request || beat.close_request) begin
                    phase_next         = beat.open_request ? PH_SETTLE_OPEN : PH_SETTLE_CLOSE;
                    direction_next     = !beat.open_request;
                    enable_n_next      = 1'b0;
                    delay_count_next   = 32'd0;
                    pulse_is_high_next = 1'b0;
                    motor_active_next  = 2'b00;
                end
            end
            PH_SETTLE_OPEN, PH_SETTLE_CLOSE: begin
                if (delay_count_reg >= cfg.settle_ticks) begin
                    phase_next = (phase_reg == PH_SETTLE_OPEN) ? PH_OPENING : PH_CLOSING;
                    do_step    = 1'b1;
                    step_base  = 16'd0;
                end else begin
                    delay_count_next = delay_inc;
                end
            end
            PH_OPENING, PH_CLOSING: begin
                if (pulse_is_high_reg) begin
                    if (delay_count_reg >= {16'd0, hi_ticks}) begin
                        pulse_is_high_next = 1'b0;
                        delay_count_next   = 32'd1;
                    end else begin
                        delay_count_next = delay_inc;
                    end
                end else if (delay_count_reg >= {16'd0, lo_ticks}) begin
                    do_step = 1'b1;
                end else begin
                    delay_count_next = delay_inc;
                end
            end
            PH_WAITING: begin
                if (delay_count_reg >= cfg.close_wait_ticks) begin
                    phase_next         = PH_SETTLE_CLOSE;
                    direction_next     = 1'b1;
                    enable_n_next      = 1'b0;
                    delay_count_next   = 32'd0;
                    pulse_is_high_next = 1'b0;
                    motor_active_next  = 2'b00;
                end else begin
                    delay_count_next = delay_inc;
                end
            end
            default: begin
                phase_next         = PH_IDLE;
                pulse_is_high_next = 1'b0;
                motor_active_next  = 2'b00;
                delay_count_next   = 32'd0;
            end
        endcase

        closing   = (phase_next == PH_CLOSING);
        step_bits = closing ? {!beat.limit_closed_b, !beat.limit_closed_a}
                            : {!beat.limit_open_b, !beat.limit_open_a};

        if (do_step) begin
            step_count_next = step_base;
            if ((step_base >= cfg.max_step_count) || (step_bits == 2'b00)) begin
                // end of move
                pulse_is_high_next = 1'b0;
                motor_active_next  = 2'b00;
                delay_count_next   = 32'd0;
                if (closing) begin
                    phase_next    = PH_IDLE;
                    enable_n_next = 1'b1;
                end else begin
                    phase_next = PH_WAITING;
                end
            end else begin
                motor_active_next  = step_bits;
                pulse_is_high_next = 1'b1;
                delay_count_next   = 32'd1;
                step_count_next    = step_base + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            pulse_is_high_reg <= 1'b0;
            delay_count_reg   <= 32'd0;
            step_count_reg    <= 16'd0;
            motor_active_reg  <= 2'b00;
            direction_reg     <= 1'b0;
            enable_n_reg      <= 1'b0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            pulse_is_high_reg <= pulse_is_high_next;
            delay_count_reg   <= delay_count_next;
            step_count_reg    <= step_count_next;
            motor_active_reg  <= motor_active_next;
            direction_reg     <= direction_next;
            enable_n_reg      <= enable_n_next;
        end
    end

    assign result.step_out_a   = pulse_is_high_next && motor_active_next[0];
    assign result.step_out_b   = pulse_is_high_next && motor_active_next[1];
    assign result.dir_out      = direction_next;
    assign result.enable_n_out = enable_n_next;
    assign result.phase_out    = phase_code(phase_next);

endmodule

>>> hw/rtl/tdss_out_reg.sv
// -----------------------------------------------------------------------------
// Twin door stepper sequencer - result register
// Holds one result beat until the downstream side takes it.
// -----------------------------------------------------------------------------
module tdss_out_reg
    import tdss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    output logic      load_ready,
    input  out_beat_t load_beat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_beat
);

    logic      valid_reg;
    out_beat_t beat_reg;

    assign load_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= load_beat;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

>>> hw/rtl/twin_door_stepper_sequencer_unit.sv
// -----------------------------------------------------------------------------
// Twin door stepper sequencer unit
// Sequences two door steppers through settle, step and wait phases per tick.
// -----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  s_       | s_valid / s_ready    | request levels and four limit switches
//  m_       | m_valid / m_ready    | step levels, direction, enable_n, phase
//  cfg_     | cfg_we               | cfg_index, cfg_wdata (five timing registers)
//
//  One beat in gives one beat out; a new beat is taken every cycle while m_ does not stall.
//  Each beat passes the input register, then the core logic into the result register.
//  A stall on m_ holds the result register and backs up through the input register.
//  Reset (aresetn low, synchronous) returns to idle with the drivers enabled.
// -----------------------------------------------------------------------------
module twin_door_stepper_sequencer_unit
    import tdss_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_open_request,
    input  logic                   s_close_request,
    input  logic                   s_limit_open_a,
    input  logic                   s_limit_closed_a,
    input  logic                   s_limit_open_b,
    input  logic                   s_limit_closed_b,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_step_out_a,
    output logic                   m_step_out_b,
    output logic                   m_dir_out,
    output logic                   m_enable_n_out,
    output logic [2:0]             m_phase_out
);

    cfg_t      cfg;
    in_beat_t  s_beat;
    in_beat_t  hold_beat;
    logic      hold_valid;
    logic      load_ready;
    logic      advance;
    out_beat_t core_result;
    out_beat_t m_beat;

    assign s_beat.open_request   = s_open_request;
    assign s_beat.close_request  = s_close_request;
    assign s_beat.limit_open_a   = s_limit_open_a;
    assign s_beat.limit_closed_a = s_limit_closed_a;
    assign s_beat.limit_open_b   = s_limit_open_b;
    assign s_beat.limit_closed_b = s_limit_closed_b;

    assign advance = hold_valid && load_ready;

    tdss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tdss_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_beat    (s_beat),
        .hold_valid (hold_valid),
        .hold_take  (advance),
        .hold_beat  (hold_beat)
    );

    tdss_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .beat    (hold_beat),
        .result  (core_result)
    );

    tdss_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .load_ready (load_ready),
        .load_beat  (core_result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_beat   (m_beat)
    );

    assign m_step_out_a   = m_beat.step_out_a;
    assign m_step_out_b   = m_beat.step_out_b;
    assign m_dir_out      = m_beat.dir_out;
    assign m_enable_n_out = m_beat.enable_n_out;
    assign m_phase_out    = m_beat.phase_out;

endmodule

>>> hw/rtl/tdss_checker.sv
// -----------------------------------------------------------------------------
// Twin door stepper sequencer - port checker
// Checks result beats seen on the top-level ports; bound to the top level.
// -----------------------------------------------------------------------------
`include "twin_door_stepper_sequencer_unit_macros.svh"

module tdss_checker
    import tdss_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_step_out_a,
    input logic       m_step_out_b,
    input logic       m_dir_out,
    input logic       m_enable_n_out,
    input logic [2:0] m_phase_out
);

    logic       moving;
    logic       open_side;
    logic       close_side;
    logic       step_any;
    logic       stalled;
    logic [6:0] out_bits;

    assign moving     = (m_phase_out == PHC_OPENING) || (m_phase_out == PHC_CLOSING);
    assign open_side  = (m_phase_out == PHC_SETTLE_OPEN) || (m_phase_out == PHC_OPENING)
                        || (m_phase_out == PHC_WAITING);
    assign close_side = (m_phase_out == PHC_SETTLE_CLOSE) || (m_phase_out == PHC_CLOSING);
    assign step_any   = m_valid && (m_step_out_a || m_step_out_b);
    assign stalled    = m_valid && !m_ready;
    assign out_bits   = {m_step_out_a, m_step_out_b, m_dir_out, m_enable_n_out, m_phase_out};

    // step pulses only during a move
    `TDSS_ASSERT_SAME(a_step_in_move, aclk, aresetn, step_any, moving)
    // open phases run with open direction and drivers enabled
    `TDSS_ASSERT_SAME(a_open_dir, aclk, aresetn, m_valid && open_side, !m_dir_out && !m_enable_n_out)
    // close phases run with close direction and drivers enabled
    `TDSS_ASSERT_SAME(a_close_dir, aclk, aresetn, m_valid && close_side, m_dir_out && !m_enable_n_out)
    // stalled result beat holds
    `TDSS_ASSERT_NEXT(a_out_hold, aclk, aresetn, stalled, m_valid && $stable(out_bits))

endmodule

bind twin_door_stepper_sequencer_unit tdss_checker u_tdss_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_step_out_a   (m_step_out_a),
    .m_step_out_b   (m_step_out_b),
    .m_dir_out      (m_dir_out),
    .m_enable_n_out (m_enable_n_out),
    .m_phase_out    (m_phase_out)
);

>>> sim/door_seq_check_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Door sequencer scoreboard
// Tracks timing registers and sequencer state on every accepted input beat,
// predicts the result beat and checks each result beat against the oldest
// prediction.
// -----------------------------------------------------------------------------
package door_seq_check_pkg;

    import tdss_pkg::*;

    class door_seq_scoreboard;

        logic [15:0] pulse_high;
        logic [15:0] pulse_low;
        logic [15:0] step_limit;
        logic [31:0] close_wait;
        logic [31:0] settle_len;

        logic [2:0]  phase;
        logic        pulse_on;
        logic [31:0] tick_cnt;
        logic [15:0] step_cnt;
        logic [1:0]  motor_mask;
        logic        dir_close;
        logic        drv_off;

        out_beat_t   pending_q[$];
        int          errors;
        int          beats_checked;
        int          moves_done;
        int          moves_timed_out;

        function new();
            pulse_high      = PULSE_HIGH_RST;
            pulse_low       = PULSE_LOW_RST;
            step_limit      = MAX_STEP_RST;
            close_wait      = CLOSE_WAIT_RST;
            settle_len      = SETTLE_RST;
            phase           = PHC_IDLE;
            pulse_on        = 1'b0;
            tick_cnt        = '0;
            step_cnt        = '0;
            motor_mask      = '0;
            dir_close       = 1'b0;
            drv_off         = 1'b0;
            errors          = 0;
            beats_checked   = 0;
            moves_done      = 0;
            moves_timed_out = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [31:0] value);
            case (idx)
                CFG_PULSE_HIGH: pulse_high = value[15:0];
                CFG_PULSE_LOW:  pulse_low  = value[15:0];
                CFG_MAX_STEP:   step_limit = value[15:0];
                CFG_CLOSE_WAIT: close_wait = value;
                CFG_SETTLE:     settle_len = value;
                default: ;
            endcase
        endfunction

        function void finish_move();
            moves_done++;
            pulse_on   = 1'b0;
            motor_mask = '0;
            tick_cnt   = '0;
            if (phase == PHC_OPENING) begin
                phase = PHC_WAITING;
            end else begin
                phase   = PHC_IDLE;
                drv_off = 1'b1;
            end
        endfunction

        function void start_step(in_beat_t b);
            logic       lim_a;
            logic       lim_b;
            logic [1:0] need;
            lim_a = (phase == PHC_CLOSING) ? b.limit_closed_a : b.limit_open_a;
            lim_b = (phase == PHC_CLOSING) ? b.limit_closed_b : b.limit_open_b;
            if (step_cnt >= step_limit) begin
                moves_timed_out++;
                finish_move();
                return;
            end
            need = {~lim_b, ~lim_a};
            if (need == 2'b00) begin
                finish_move();
                return;
            end
            motor_mask = need;
            pulse_on   = 1'b1;
            tick_cnt   = 32'd1;
            step_cnt   = step_cnt + 16'd1;
        endfunction

        function void enter_settle(logic [2:0] next_phase, logic close_dir);
            phase      = next_phase;
            dir_close  = close_dir;
            drv_off    = 1'b0;
            tick_cnt   = '0;
            pulse_on   = 1'b0;
            motor_mask = '0;
        endfunction

        function void note_input(in_beat_t b);
            logic [15:0] hi_len;
            logic [15:0] lo_len;
            out_beat_t   r;
            hi_len = (pulse_high == 16'd0) ? 16'd1 : pulse_high;
            lo_len = (pulse_low == 16'd0) ? 16'd1 : pulse_low;
            case (phase)
                PHC_IDLE: begin
                    if (b.open_request)
                        enter_settle(PHC_SETTLE_OPEN, 1'b0);
                    else if (b.close_request)
                        enter_settle(PHC_SETTLE_CLOSE, 1'b1);
                end
                PHC_SETTLE_OPEN, PHC_SETTLE_CLOSE: begin
                    if (tick_cnt >= settle_len) begin
                        phase    = (phase == PHC_SETTLE_OPEN) ? PHC_OPENING : PHC_CLOSING;
                        step_cnt = '0;
                        start_step(b);
                    end else begin
                        tick_cnt++;
                    end
                end
                PHC_OPENING, PHC_CLOSING: begin
                    if (pulse_on) begin
                        if (tick_cnt >= hi_len) begin
                            pulse_on = 1'b0;
                            tick_cnt = 32'd1;
                        end else begin
                            tick_cnt++;
                        end
                    end else if (tick_cnt >= lo_len) begin
                        start_step(b);
                    end else begin
                        tick_cnt++;
                    end
                end
                PHC_WAITING: begin
                    if (tick_cnt >= close_wait)
                        enter_settle(PHC_SETTLE_CLOSE, 1'b1);
                    else
                        tick_cnt++;
                end
                default: begin
                    phase      = PHC_IDLE;
                    pulse_on   = 1'b0;
                    motor_mask = '0;
                    tick_cnt   = '0;
                end
            endcase
            r.step_out_a   = pulse_on & motor_mask[0];
            r.step_out_b   = pulse_on & motor_mask[1];
            r.dir_out      = dir_close;
            r.enable_n_out = drv_off;
            r.phase_out    = phase;
            pending_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [2:0] want, logic [2:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, actual %p", $time, got);
                return;
            end
            want = pending_q.pop_front();
            beats_checked++;
            compare_field("step_out_a", {2'b00, want.step_out_a}, {2'b00, got.step_out_a});
            compare_field("step_out_b", {2'b00, want.step_out_b}, {2'b00, got.step_out_b});
            compare_field("dir_out", {2'b00, want.dir_out}, {2'b00, got.dir_out});
            compare_field("enable_n_out", {2'b00, want.enable_n_out},
                          {2'b00, got.enable_n_out});
            compare_field("phase_out", want.phase_out, got.phase_out);
        endfunction

    endclass

endpackage

>>> sim/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Twin door stepper sequencer testbench
// Drives tick beats with random gaps and back-pressure on the result side,
// steps through several timing register settings, all-zero and all-max among them,
// and checks every result beat against the scoreboard prediction.
// -----------------------------------------------------------------------------
module tb;

    import tdss_pkg::*;
    import door_seq_check_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 10;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_open_request;
    logic                   s_close_request;
    logic                   s_limit_open_a;
    logic                   s_limit_closed_a;
    logic                   s_limit_open_b;
    logic                   s_limit_closed_b;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_step_out_a;
    logic                   m_step_out_b;
    logic                   m_dir_out;
    logic                   m_enable_n_out;
    logic [2:0]             m_phase_out;

    door_seq_scoreboard sb = new();
    bit                 no_idle;
    int                 settings_used;
    in_beat_t           lim_state;

    // open, close, limit_open_a, limit_closed_a, limit_open_b, limit_closed_b
    logic [5:0] directed_beats [] = '{
        6'b000000, 6'b110000, 6'b000000, 6'b000000, 6'b000000, 6'b001000,
        6'b001000, 6'b001000, 6'b001010, 6'b001010, 6'b101010, 6'b011010,
        6'b000000, 6'b000000, 6'b000101, 6'b000101, 6'b000101, 6'b010101,
        6'b010000, 6'b000000, 6'b111111, 6'b000000
    };

    twin_door_stepper_sequencer_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_open_request   (s_open_request),
        .s_close_request  (s_close_request),
        .s_limit_open_a   (s_limit_open_a),
        .s_limit_closed_a (s_limit_closed_a),
        .s_limit_open_b   (s_limit_open_b),
        .s_limit_closed_b (s_limit_closed_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_out_a     (m_step_out_a),
        .m_step_out_b     (m_step_out_b),
        .m_dir_out        (m_dir_out),
        .m_enable_n_out   (m_enable_n_out),
        .m_phase_out      (m_phase_out)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // mostly persistent switch levels with request pulses, some pure noise
    function automatic in_beat_t next_tick_beat();
        in_beat_t b;
        if ($urandom_range(0, 9) == 0) begin
            b = in_beat_t'($urandom_range(0, 63));
        end else begin
            b = lim_state;
            if ($urandom_range(0, 7) == 0) b.limit_open_a   = ~b.limit_open_a;
            if ($urandom_range(0, 7) == 0) b.limit_closed_a = ~b.limit_closed_a;
            if ($urandom_range(0, 7) == 0) b.limit_open_b   = ~b.limit_open_b;
            if ($urandom_range(0, 7) == 0) b.limit_closed_b = ~b.limit_closed_b;
            lim_state = b;
            b.open_request  = ($urandom_range(0, 5) == 0);
            b.close_request = ($urandom_range(0, 5) == 0);
        end
        return b;
    endfunction

    task automatic send_beat(in_beat_t b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_open_request   <= b.open_request;
        s_close_request  <= b.close_request;
        s_limit_open_a   <= b.limit_open_a;
        s_limit_closed_a <= b.limit_closed_a;
        s_limit_open_b   <= b.limit_open_b;
        s_limit_closed_b <= b.limit_closed_b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic load_setting(logic [15:0] ph, logic [15:0] pl, logic [15:0] ms,
                                logic [31:0] cw, logic [31:0] st);
        logic [31:0] vals [5];
        cfg_index_t  idx;
        vals = '{{16'h0000, ph}, {16'h0000, pl}, {16'h0000, ms}, cw, st};
        for (int i = 0; i < 5; i++) begin
            idx       = cfg_index_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[i];
            sb.write_reg(idx, vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    task automatic run_ticks(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0) drain();
            send_beat(next_tick_beat());
        end
        drain();
    endtask

    initial begin
        aresetn          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        s_valid          <= 1'b0;
        s_open_request   <= 1'b0;
        s_close_request  <= 1'b0;
        s_limit_open_a   <= 1'b0;
        s_limit_closed_a <= 1'b0;
        s_limit_open_b   <= 1'b0;
        s_limit_closed_b <= 1'b0;
        lim_state        = '0;
        no_idle          = 1'b0;
        settings_used    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values
        send_beat(in_beat_t'(6'b000000));
        send_beat(in_beat_t'(6'b010000));
        drain();

        load_setting(16'd1, 16'd2, 16'd3, 32'd1, 32'd1);
        foreach (directed_beats[i]) send_beat(in_beat_t'(directed_beats[i]));
        drain();

        load_setting(16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        run_ticks(60);
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_ticks(40);
        load_setting(16'hFFFF, 16'd1, 16'hFFFF, 32'd0, 32'd0);
        run_ticks(40);
        repeat (6) begin
            load_setting(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                         16'($urandom_range(1, 6)), $urandom_range(0, 8),
                         $urandom_range(0, 4));
            run_ticks(60);
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending_q.size() != 0) begin
            sb.errors += sb.pending_q.size();
            $display("%0t: %0d result beats never arrived", $time, sb.pending_q.size());
        end
        $display("Covered %0d result beats over %0d register settings",
                 sb.beats_checked, settings_used);
        $display("Door moves finished: %0d, ended by step limit: %0d",
                 sb.moves_done, sb.moves_timed_out);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        int        gap;
        out_beat_t got;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.step_out_a   = m_step_out_a;
            got.step_out_b   = m_step_out_b;
            got.dir_out      = m_dir_out;
            got.enable_n_out = m_enable_n_out;
            got.phase_out    = m_phase_out;
            sb.check_result(got);
        end
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall = 0;
            else
                stall++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, stall);
        $display("Verification failed");
        $finish;
    end

endmodule
